// File: rtl/lcgd_pkg.sv
// Shared types and constants of the light-cover gesture detector.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lcgd_pkg;

   // field widths of the channels
   localparam int LIGHT_W = 12;
   localparam int NOW_W   = 32;
   localparam int AMB_W   = 12;
   localparam int CFG_W   = 16;
   localparam int IDX_W   = 4;

   // internal precision actually used from the fields
   localparam int SAMPLE_BITS = 12;
   localparam int TIME_BITS   = 32;
   localparam int CMP_W       = (SAMPLE_BITS > AMB_W) ? SAMPLE_BITS : AMB_W;

   // register indexes
   localparam logic [IDX_W-1:0] REG_AMBIENT_MIN = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_COVER_RATIO = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_COVER_MIN   = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_COOLDOWN    = IDX_W'(3);

   // register reset values
   localparam logic [AMB_W-1:0] AMBIENT_MIN_RST = AMB_W'(80);
   localparam logic [CFG_W-1:0] COVER_RATIO_RST = CFG_W'(22938);
   localparam logic [CFG_W-1:0] COVER_MIN_RST   = CFG_W'(200);
   localparam logic [CFG_W-1:0] COOLDOWN_RST    = CFG_W'(1000);

   typedef struct packed {
      logic [LIGHT_W-1:0] light_sample;
      logic [NOW_W-1:0]   now_ms;
   } lcgd_req_type;

   typedef struct packed {
      logic               trigger;
      logic               is_covered;
      logic               armed;
      logic [LIGHT_W-1:0] baseline_level;
   } lcgd_rsp_type;

   typedef struct packed {
      logic [AMB_W-1:0] ambient_min;
      logic [CFG_W-1:0] cover_ratio_q16;
      logic [CFG_W-1:0] cover_min_ms;
      logic [CFG_W-1:0] cooldown_ms;
   } lcgd_cfg_type;

endpackage

`default_nettype wire

// File: rtl/light_cover_gesture_detector.sv
// Top level of the light-cover gesture detector: configuration registers, input register, core, result register.
// Depends on lcgd_pkg, lcgd_csr and lcgd_core.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | lcgd_req_type (light_sample, now_ms)
//   rsp     | out       | rsp_valid/rsp_stall | lcgd_rsp_type (trigger .. baseline_level)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// A request is held in the input register, then passes through the core into
// the result register. A new request is taken every cycle while rsp_stall is
// low. The core's state update is one combinational path between registers, so
// the core's update-multiply-compare path sets the clock. Reset clears the valid
// flags and core state and loads the register defaults; a stall holds the result register and a full input register.
`default_nettype none

module light_cover_gesture_detector
   import lcgd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lcgd_req_type     req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lcgd_rsp_type     rsp_payload,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   lcgd_cfg_type cfg;
   lcgd_req_type in_data_ff;
   logic         in_valid_ff, in_valid_in;
   lcgd_rsp_type out_data_ff;
   logic         out_valid_ff, out_valid_in;
   lcgd_rsp_type core_rsp;
   logic         out_free;
   logic         step;
   logic         req_take;

   lcgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcgd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_data_ff <= req_payload;
      if (step)
         out_data_ff <= core_rsp;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

// File: rtl/lcgd_csr.sv
// Configuration registers of the light-cover gesture detector.
// Depends on lcgd_pkg.
`default_nettype none

module lcgd_csr
   import lcgd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   output      lcgd_cfg_type     cfg
);

   lcgd_cfg_type cfg_ff, cfg_in;
   logic         wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            REG_AMBIENT_MIN: cfg_in.ambient_min     = csr_wdata[AMB_W-1:0];
            REG_COVER_RATIO: cfg_in.cover_ratio_q16 = csr_wdata;
            REG_COVER_MIN:   cfg_in.cover_min_ms    = csr_wdata;
            REG_COOLDOWN:    cfg_in.cooldown_ms     = csr_wdata;
            default:         cfg_in = cfg_ff;  // unknown index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ambient_min     <= AMBIENT_MIN_RST;
         cfg_ff.cover_ratio_q16 <= COVER_RATIO_RST;
         cfg_ff.cover_min_ms    <= COVER_MIN_RST;
         cfg_ff.cooldown_ms     <= COOLDOWN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/lcgd_core.sv
// Baseline tracking, cover qualification and trigger state of the detector.
// Depends on lcgd_pkg; one request is processed per asserted step.
`default_nettype none

module lcgd_core
   import lcgd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire lcgd_req_type req,
   input  wire lcgd_cfg_type cfg,
   output      lcgd_rsp_type rsp
);

   logic [SAMPLE_BITS-1:0] baseline_ff, baseline_in;
   logic                   cover_active_ff, cover_active_in;
   logic [TIME_BITS-1:0]   cover_start_ff, cover_start_in;
   logic [TIME_BITS-1:0]   last_trig_ff, last_trig_in;

   logic [SAMPLE_BITS-1:0]    sample;
   logic [TIME_BITS-1:0]      now;
   logic [SAMPLE_BITS+3:0]    avg_sum;
   logic [SAMPLE_BITS-1:0]    base_upd;
   logic [SAMPLE_BITS+15:0]   prod;
   logic [SAMPLE_BITS-1:0]    threshold;
   logic [TIME_BITS-1:0]      held;
   logic [TIME_BITS-1:0]      since;
   logic                      armed;
   logic                      covered;
   logic                      qualified;
   logic                      fire;

   assign sample = SAMPLE_BITS'(req.light_sample);
   assign now    = TIME_BITS'(req.now_ms);

   // 15*b + s as (b << 4) - b + s
   assign avg_sum = ({baseline_ff, 4'b0000} - (SAMPLE_BITS+4)'(baseline_ff))
                    + (SAMPLE_BITS+4)'(sample);

   always_comb begin
      if (cover_active_ff)
         base_upd = baseline_ff;               // frozen during a cover
      else if (baseline_ff != '0)
         base_upd = avg_sum[SAMPLE_BITS+3:4];
      else
         base_upd = sample;                    // first load
   end

   assign armed     = CMP_W'(base_upd) >= CMP_W'(cfg.ambient_min);
   assign prod      = (SAMPLE_BITS+16)'(base_upd) * (SAMPLE_BITS+16)'(cfg.cover_ratio_q16);
   assign threshold = prod[SAMPLE_BITS+15:16];
   assign covered   = armed && (sample < threshold);

   assign held      = now - cover_start_ff;
   assign since     = now - last_trig_ff;
   assign qualified = (held >= TIME_BITS'(cfg.cover_min_ms))
                      && (since >= TIME_BITS'(cfg.cooldown_ms));
   assign fire      = covered && cover_active_ff && qualified;

   assign baseline_in     = base_upd;
   assign cover_active_in = covered && !fire;
   assign cover_start_in  = (covered && !cover_active_ff) ? now : cover_start_ff;
   assign last_trig_in    = fire ? now : last_trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff     <= '0;
         cover_active_ff <= 1'b0;
         cover_start_ff  <= '0;
         last_trig_ff    <= '0;
      end else if (step) begin
         baseline_ff     <= baseline_in;
         cover_active_ff <= cover_active_in;
         cover_start_ff  <= cover_start_in;
         last_trig_ff    <= last_trig_in;
      end
   end

   assign rsp.trigger        = fire;
   assign rsp.is_covered     = covered;
   assign rsp.armed          = armed;
   assign rsp.baseline_level = LIGHT_W'(base_upd);

endmodule

`default_nettype wire

// File: rtl/lcgd_checker.sv
// Port-level checks of the light-cover gesture detector, bound to the top level.
// Depends on lcgd_pkg and light_cover_gesture_detector.
`default_nettype none

module lcgd_checker
   import lcgd_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire lcgd_rsp_type rsp_payload
);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // a trigger needs a covered sample, cover needs an armed baseline
   a_trig_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.trigger || rsp_payload.is_covered))
      else $error("trigger without cover");

   a_cov_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.is_covered || rsp_payload.armed))
      else $error("cover while not armed");

endmodule

bind light_cover_gesture_detector lcgd_checker u_lcgd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
